/* sv/mqpl_pkg.sv */
// Shared opcodes, status codes and the command/status bundles between the
// controller and the datapath of the process link manager. No dependencies.
`timescale 1ns / 1ps

package mqpl_pkg;

  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_INSERT    = 3'd2;
  localparam logic [2:0] OP_REM_HEAD  = 3'd3;
  localparam logic [2:0] OP_REM_NAMED = 3'd4;
  localparam logic [2:0] OP_PEEK      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic cap;        // capture request fields
    logic alloc_rd;   // read free chain at free top
    logic alloc_pop;  // pop free stack
    logic free_do;    // push entry on free stack
    logic ins_claim;  // mark lowest free slot in use
    logic ins_first;  // insert into empty queue
    logic tail_rd;    // read tail table
    logic tl_load;    // latch tail, read its next link
    logic ins_mid;    // new link -> old head
    logic ins_end;    // old tail -> new link, new tail
    logic peek_done;
    logic head_sel;   // target = head, pred = tail
    logic walk_init;  // cur = head, prev = tail
    logic walk_rd;    // read next of cur
    logic walk_adv;   // prev = cur, cur = next
    logic tgt_sel;    // target = cur, pred = prev
    logic unlink;
    logic fail_empty;
    logic fail_full;
    logic out_load;
  } mqpl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       p_ok;
    logic       q_ok;
    logic       tail_vld;
    logic       ft_ok;
    logic       joined;
    logic       slot_free;
    logic       tl_is_p;
    logic       cur_is_tl;
    logic       cur_is_p;
    logic       out_busy;
  } mqpl_stat_t;

endpackage

/* sv/mqpl_ifs.sv */
// Request and response channel interfaces of the process link manager.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface mqpl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [5:0] queue_number;
  logic [4:0] process_number;

  modport source (output valid, opcode, queue_number, process_number, input ready);
  modport sink (input valid, opcode, queue_number, process_number, output ready);
endinterface

interface mqpl_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] process_out;
  logic [1:0] status;

  modport source (output valid, process_out, status, input ready);
  modport sink (input valid, process_out, status, output ready);
endinterface

/* sv/multi_queue_process_link_manager_top.sv */
// Process link manager: a table of process entries kept on a free stack and
// on up to LINKS_PER_PROC circular queues each, one result per request. One
// request is worked at a time, and no new request is accepted until the
// result register has loaded, which waits while the previous result is still
// held. Remove by name walks the queue from the head, each step of the walk
// being one registered read of the link memory. The link, tail and free
// chain memories are not cleared at reset; the in-use, tail-valid and
// chain-written bits, the free top and the result valid are.
// Depends on mqpl_pkg, mqpl_ifs, mqpl_ctrl and mqpl_dp.
`timescale 1ns / 1ps

module multi_queue_process_link_manager_top #(
  parameter int NUM_PROCS      = 32,
  parameter int LINKS_PER_PROC = 4,
  parameter int NUM_QUEUES     = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  mqpl_req_if.sink   req_i,
  mqpl_rsp_if.source rsp_o
);
  import mqpl_pkg::*;

  mqpl_cmd_t  cmd;
  mqpl_stat_t stat;

  mqpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mqpl_dp #(
    .NUM_PROCS      (NUM_PROCS),
    .LINKS_PER_PROC (LINKS_PER_PROC),
    .NUM_QUEUES     (NUM_QUEUES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (req_i.opcode),
    .queue_number_i   (req_i.queue_number),
    .process_number_i (req_i.process_number),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .process_out_o    (rsp_o.process_out),
    .status_o         (rsp_o.status)
  );

endmodule

/* sv/mqpl_ctrl.sv */
// Sequencing state machine of the process link manager.
// Depends on mqpl_pkg; drives the datapath through mqpl_cmd_t.
`timescale 1ns / 1ps

module mqpl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mqpl_pkg::mqpl_stat_t stat_i,
  output mqpl_pkg::mqpl_cmd_t  cmd_o
);
  import mqpl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_ALLOC2 = 4'd2;
  localparam logic [3:0] S_TAIL   = 4'd3;
  localparam logic [3:0] S_HEAD   = 4'd4;
  localparam logic [3:0] S_INS2   = 4'd5;
  localparam logic [3:0] S_WCHK   = 4'd6;
  localparam logic [3:0] S_WSTEP  = 4'd7;
  localparam logic [3:0] S_UNLINK = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       mode_q, mode_d;  // set: target is the tail, walk looks for its predecessor

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    mode_d  = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_ALLOC: begin
            if (stat_i.ft_ok) begin
              cmd_o.alloc_rd = 1'b1;
              state_d        = S_ALLOC2;
            end else begin
              cmd_o.fail_empty = 1'b1;
            end
          end
          OP_FREE: begin
            if (!stat_i.p_ok)       cmd_o.fail_empty = 1'b1;
            else if (stat_i.joined) cmd_o.fail_full  = 1'b1;
            else                    cmd_o.free_do    = 1'b1;
          end
          OP_INSERT: begin
            if (!(stat_i.p_ok && stat_i.q_ok)) begin
              cmd_o.fail_empty = 1'b1;
            end else if (!stat_i.slot_free) begin
              cmd_o.fail_full = 1'b1;
            end else if (stat_i.tail_vld) begin
              cmd_o.ins_claim = 1'b1;
              cmd_o.tail_rd   = 1'b1;
              state_d         = S_TAIL;
            end else begin
              cmd_o.ins_claim = 1'b1;
              cmd_o.ins_first = 1'b1;
            end
          end
          OP_REM_HEAD, OP_PEEK: begin
            if (stat_i.q_ok && stat_i.tail_vld) begin
              cmd_o.tail_rd = 1'b1;
              state_d       = S_TAIL;
            end else begin
              cmd_o.fail_empty = 1'b1;
            end
          end
          OP_REM_NAMED: begin
            if (stat_i.p_ok && stat_i.q_ok && stat_i.tail_vld) begin
              cmd_o.tail_rd = 1'b1;
              state_d       = S_TAIL;
            end else begin
              cmd_o.fail_empty = 1'b1;
            end
          end
          default: cmd_o.fail_empty = 1'b1;
        endcase
      end
      S_ALLOC2: begin
        cmd_o.alloc_pop = 1'b1;
        state_d         = S_DONE;
      end
      S_TAIL: begin
        cmd_o.tl_load = 1'b1;
        state_d       = S_HEAD;
      end
      S_HEAD: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_INSERT: begin
            cmd_o.ins_mid = 1'b1;
            state_d       = S_INS2;
          end
          OP_PEEK: cmd_o.peek_done = 1'b1;
          OP_REM_HEAD: begin
            cmd_o.head_sel = 1'b1;
            state_d        = S_UNLINK;
          end
          OP_REM_NAMED: begin
            cmd_o.walk_init = 1'b1;
            mode_d          = stat_i.tl_is_p;
            state_d         = S_WCHK;
          end
          default: cmd_o.fail_empty = 1'b1;
        endcase
      end
      S_INS2: begin
        cmd_o.ins_end = 1'b1;
        state_d       = S_DONE;
      end
      S_WCHK: begin
        if (mode_q) begin
          if (stat_i.cur_is_tl) begin
            cmd_o.tgt_sel = 1'b1;
            state_d       = S_UNLINK;
          end else begin
            cmd_o.walk_rd = 1'b1;
            state_d       = S_WSTEP;
          end
        end else if (stat_i.cur_is_tl) begin
          // back at the tail: name not on this queue
          cmd_o.fail_empty = 1'b1;
          state_d          = S_DONE;
        end else if (stat_i.cur_is_p) begin
          cmd_o.tgt_sel = 1'b1;
          state_d       = S_UNLINK;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WSTEP;
        end
      end
      S_WSTEP: begin
        cmd_o.walk_adv = 1'b1;
        state_d        = S_WCHK;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* sv/mqpl_dp.sv */
// Datapath of the process link manager: link, tail and free chain memories,
// in-use and tail-valid bits, walk registers and the result register.
// Depends on mqpl_pkg; commanded by mqpl_ctrl.
`timescale 1ns / 1ps

module mqpl_dp #(
  parameter int NUM_PROCS      = 32,
  parameter int LINKS_PER_PROC = 4,
  parameter int NUM_QUEUES     = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0]           opcode_i,
  input  logic [5:0]           queue_number_i,
  input  logic [4:0]           process_number_i,
  input  mqpl_pkg::mqpl_cmd_t  cmd_i,
  output mqpl_pkg::mqpl_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [4:0]           process_out_o,
  output logic [1:0]           status_o
);
  import mqpl_pkg::*;

  localparam int NL  = NUM_PROCS * LINKS_PER_PROC;
  localparam int PW  = $clog2(NUM_PROCS);
  localparam int SW  = (LINKS_PER_PROC > 1) ? $clog2(LINKS_PER_PROC) : 1;
  localparam int LW  = $clog2(NL);
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int FW  = $clog2(NUM_PROCS + 1);
  localparam int LKW = PW + SW;

  function automatic logic [LW-1:0] la(logic [PW-1:0] p, logic [SW-1:0] s);
    return LW'(32'(p) * LINKS_PER_PROC + 32'(s));
  endfunction

  // storage
  logic [LKW-1:0] link_mem [NL];
  logic [LKW-1:0] tail_mem [NUM_QUEUES];
  logic [FW-1:0]  fc_mem   [NUM_PROCS];
  logic [NL-1:0]         in_use_q;
  logic [NUM_QUEUES-1:0] tail_vld_q;
  logic [NUM_PROCS-1:0]  fc_wr_q;
  logic [FW-1:0]         ft_q;
  logic                  out_valid_q;

  // request and walk registers
  logic [2:0]     op_q;
  logic [QW-1:0]  q_q;
  logic [PW-1:0]  p_q;
  logic           p_ok_q, q_ok_q;
  logic [SW-1:0]  ins_s_q;
  logic [LKW-1:0] rdn_q, tail_rd_q, tl_q, cur_q, prev_q, tgt_q, pred_q;
  logic [FW-1:0]  fc_rd_q;
  logic [4:0]     res_p_q, out_p_q;
  logic [1:0]     res_st_q, out_st_q;

  // lowest free slot of the captured entry
  logic [SW-1:0] slot_c;
  logic          slot_free, joined;
  always_comb begin
    slot_c    = '0;
    slot_free = 1'b0;
    joined    = 1'b0;
    for (int s = LINKS_PER_PROC - 1; s >= 0; s--) begin
      if (!in_use_q[la(p_q, SW'(s))]) begin
        slot_free = 1'b1;
        slot_c    = SW'(s);
      end else begin
        joined = 1'b1;
      end
    end
  end

  logic [PW-1:0] tl_p, cur_p, tgt_p;
  logic [PW-1:0] ft_idx;
  logic          pred_is_tgt;
  assign tl_p        = tl_q[LKW-1:SW];
  assign cur_p       = cur_q[LKW-1:SW];
  assign tgt_p       = tgt_q[LKW-1:SW];
  assign ft_idx      = ft_q[PW-1:0];
  assign pred_is_tgt = (pred_q == tgt_q);

  assign stat_o.op        = op_q;
  assign stat_o.p_ok      = p_ok_q;
  assign stat_o.q_ok      = q_ok_q;
  assign stat_o.tail_vld  = tail_vld_q[q_q];
  assign stat_o.ft_ok     = (32'(ft_q) < NUM_PROCS);
  assign stat_o.joined    = joined;
  assign stat_o.slot_free = slot_free;
  assign stat_o.tl_is_p   = (tl_p == p_q);
  assign stat_o.cur_is_tl = (cur_q == tl_q);
  assign stat_o.cur_is_p  = (cur_p == p_q);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  // link memory ports
  logic           lk_we, lk_re;
  logic [LW-1:0]  lk_wa, lk_ra;
  logic [LKW-1:0] lk_wd, lk_ra_w;
  logic           tm_we;
  logic [LKW-1:0] tm_wd;

  always_comb begin
    lk_we = 1'b0;
    lk_wa = la(p_q, slot_c);
    lk_wd = {p_q, slot_c};
    tm_we = 1'b0;
    tm_wd = {p_q, slot_c};
    if (cmd_i.ins_first) begin
      lk_we = 1'b1;
      tm_we = 1'b1;
    end else if (cmd_i.ins_mid) begin
      lk_we = 1'b1;
      lk_wa = la(p_q, ins_s_q);
      lk_wd = rdn_q;
    end else if (cmd_i.ins_end) begin
      lk_we = 1'b1;
      lk_wa = la(tl_p, tl_q[SW-1:0]);
      lk_wd = {p_q, ins_s_q};
      tm_we = 1'b1;
      tm_wd = {p_q, ins_s_q};
    end else if (cmd_i.unlink && !pred_is_tgt) begin
      lk_we = 1'b1;
      lk_wa = la(pred_q[LKW-1:SW], pred_q[SW-1:0]);
      lk_wd = rdn_q;
      tm_we = (tgt_q == tl_q);
      tm_wd = pred_q;
    end
  end

  always_comb begin
    lk_re   = cmd_i.tl_load || cmd_i.head_sel || cmd_i.walk_rd || cmd_i.tgt_sel;
    lk_ra_w = cur_q;
    if (cmd_i.tl_load)       lk_ra_w = tail_rd_q;
    else if (cmd_i.head_sel) lk_ra_w = rdn_q;
    lk_ra = la(lk_ra_w[LKW-1:SW], lk_ra_w[SW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (lk_re) rdn_q <= link_mem[lk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) tail_mem[q_q] <= tm_wd;
    if (cmd_i.tail_rd) tail_rd_q <= tail_mem[q_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.free_do) fc_mem[p_q] <= ft_q;
    if (cmd_i.alloc_rd) fc_rd_q <= fc_mem[ft_idx];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      tail_vld_q  <= '0;
      fc_wr_q     <= '0;
      ft_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins_claim) in_use_q[la(p_q, slot_c)] <= 1'b1;
      if (cmd_i.unlink) in_use_q[la(tgt_p, tgt_q[SW-1:0])] <= 1'b0;
      if (cmd_i.ins_first || cmd_i.ins_end) tail_vld_q[q_q] <= 1'b1;
      if (cmd_i.unlink && pred_is_tgt) tail_vld_q[q_q] <= 1'b0;
      if (cmd_i.free_do) begin
        fc_wr_q[p_q] <= 1'b1;
        ft_q         <= FW'(p_q);
      end
      // a chain entry never written counts as a link to i + 1
      if (cmd_i.alloc_pop) ft_q <= fc_wr_q[ft_idx] ? fc_rd_q : ft_q + FW'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= opcode_i;
      q_q    <= QW'(32'(queue_number_i));
      p_q    <= PW'(32'(process_number_i));
      p_ok_q <= (32'(process_number_i) < NUM_PROCS);
      q_ok_q <= (32'(queue_number_i) < NUM_QUEUES);
    end
    if (cmd_i.ins_claim) ins_s_q <= slot_c;
    if (cmd_i.tl_load) tl_q <= tail_rd_q;
    if (cmd_i.head_sel) begin
      tgt_q  <= rdn_q;
      pred_q <= tl_q;
    end
    if (cmd_i.walk_init) begin
      cur_q  <= rdn_q;
      prev_q <= tl_q;
    end
    if (cmd_i.walk_adv) begin
      cur_q  <= rdn_q;
      prev_q <= cur_q;
    end
    if (cmd_i.tgt_sel) begin
      tgt_q  <= cur_q;
      pred_q <= prev_q;
    end

    if (cmd_i.fail_empty) begin
      res_p_q  <= '0;
      res_st_q <= ST_EMPTY;
    end else if (cmd_i.fail_full) begin
      res_p_q  <= '0;
      res_st_q <= ST_FULL;
    end else if (cmd_i.alloc_pop) begin
      res_p_q  <= 5'(ft_idx);
      res_st_q <= ST_OK;
    end else if (cmd_i.free_do || cmd_i.ins_first || cmd_i.ins_end) begin
      res_p_q  <= '0;
      res_st_q <= ST_OK;
    end else if (cmd_i.peek_done) begin
      res_p_q  <= 5'(rdn_q[LKW-1:SW]);
      res_st_q <= ST_OK;
    end else if (cmd_i.unlink) begin
      res_p_q  <= 5'(tgt_p);
      res_st_q <= ST_OK;
    end

    if (cmd_i.out_load) begin
      out_p_q  <= res_p_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign process_out_o = out_p_q;
  assign status_o      = out_st_q;

endmodule

/* sv/mqpl_checker.sv */
// Port-level assertions for the process link manager, bound to the top.
// Depends on mqpl_pkg.
`timescale 1ns / 1ps

module mqpl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [4:0] rsp_process_i,
  input logic [1:0] rsp_status_i
);
  import mqpl_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_process_i)
      && $stable(rsp_status_i))
    else $error("response changed while stalled");

  // failed requests report process zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_process_i == 5'd0)
    else $error("nonzero process on failed request");

  // one request at a time: no transfer on the edge after a transfer
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

endmodule

bind multi_queue_process_link_manager_top mqpl_checker u_mqpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_process_i (rsp_o.process_out),
  .rsp_status_i  (rsp_o.status)
);

/* tb/sv/mqpl_checker.sv */
// Checker for the process link manager: watches the request and response
// transfers, predicts each status and process from its own copy of the link tables.
// Depends on mqpl_pkg and mqpl_ifs.
`timescale 1ns / 1ps

module mqpl_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  mqpl_req_if         req,
  mqpl_rsp_if         rsp,
  output int          errors_o,
  output int          pending_o
);
  import mqpl_pkg::*;

  localparam int NP = 32;
  localparam int NS = 4;
  localparam int NQ = 64;
  localparam int NL = NP * NS;

  typedef struct packed {
    logic [4:0] proc_id;
    logic [1:0] status;
  } outcome_t;

  logic [4:0] nxt_p[NL];
  logic [1:0] nxt_s[NL];
  logic       used[NL];
  logic [2:0] joined[NP];
  logic [5:0] chain[NP];
  logic [5:0] ftop;
  logic [4:0] tp[NQ];
  logic [1:0] ts[NQ];
  logic       tv[NQ];
  outcome_t   outcomes[$];
  int         errors;

  assign errors_o  = errors;
  assign pending_o = outcomes.size();

  function automatic int nx(int l);
    return nxt_p[l] * NS + nxt_s[l];
  endfunction

  function automatic void link_to(int l, int t);
    nxt_p[l] = 5'(t / NS);
    nxt_s[l] = 2'(t % NS);
  endfunction

  function automatic bit detach(int q, int target);
    int tl, pred, i;
    tl = tp[q] * NS + ts[q];
    pred = tl;
    for (i = 0; i < NL; i++) begin
      if (nx(pred) == target) break;
      pred = nx(pred);
    end
    if (i == NL) return 0;
    if (pred == target) begin
      tv[q] = 0; tp[q] = 0; ts[q] = 0;
    end else begin
      link_to(pred, nx(target));
      if (target == tl) begin
        tp[q] = 5'(pred / NS);
        ts[q] = 2'(pred % NS);
      end
    end
    used[target] = 0;
    link_to(target, 0);
    if (joined[target / NS] > 0) joined[target / NS]--;
    return 1;
  endfunction

  function automatic outcome_t apply_request(logic [2:0] op, int q, int p);
    outcome_t o;
    int s, tl, cur, i, target, l;
    bit hit;
    o = '{proc_id: 0, status: ST_EMPTY};
    case (op)
      OP_ALLOC: begin
        if (ftop < NP) begin
          o.proc_id = 5'(ftop);
          ftop = chain[ftop];
          o.status = ST_OK;
        end
      end
      OP_FREE: begin
        if (joined[p] != 0) o.status = ST_FULL;
        else begin
          for (s = 0; s < NS; s++) begin
            used[p * NS + s] = 0;
            link_to(p * NS + s, 0);
          end
          chain[p] = ftop;
          ftop = 6'(p);
          o.status = ST_OK;
        end
      end
      OP_INSERT: begin
        for (s = 0; s < NS; s++) if (!used[p * NS + s]) break;
        if (joined[p] >= NS || s == NS) o.status = ST_FULL;
        else begin
          l = p * NS + s;
          used[l] = 1;
          if (!tv[q]) link_to(l, l);
          else begin
            tl = tp[q] * NS + ts[q];
            link_to(l, nx(tl));
            link_to(tl, l);
          end
          tp[q] = 5'(p); ts[q] = 2'(s); tv[q] = 1;
          joined[p]++;
          o.status = ST_OK;
        end
      end
      OP_REM_HEAD, OP_PEEK: begin
        if (tv[q]) begin
          target = nx(tp[q] * NS + ts[q]);
          if (op == OP_PEEK || detach(q, target)) begin
            o.proc_id = 5'(target / NS);
            o.status = ST_OK;
          end
        end
      end
      OP_REM_NAMED: begin
        if (tv[q]) begin
          tl = tp[q] * NS + ts[q];
          hit = 0;
          target = tl;
          if (tl / NS == p) hit = 1;
          else begin
            cur = nx(tl);
            for (i = 0; i < NL && cur != tl; i++) begin
              if (cur / NS == p) begin
                hit = 1; target = cur; break;
              end
              cur = nx(cur);
            end
          end
          if (hit && detach(q, target)) begin
            o.proc_id = 5'(p);
            o.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    if (o.status != ST_OK) o.proc_id = 0;
    return o;
  endfunction

  task automatic report(string what);
    $display("%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) begin
        nxt_p[i] = 0; nxt_s[i] = 0; used[i] = 0;
      end
      for (int i = 0; i < NP; i++) begin
        joined[i] = 0; chain[i] = 6'(i + 1);
      end
      for (int i = 0; i < NQ; i++) begin
        tp[i] = 0; ts[i] = 0; tv[i] = 0;
      end
      ftop = 0;
      outcomes.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{proc_id: rsp.process_out, status: rsp.status};
        if (outcomes.size() == 0) report("response transfer with nothing expected");
        else begin
          want = outcomes.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.proc_id !== want.proc_id)
            report($sformatf("process %0d, expected %0d", got.proc_id, want.proc_id));
        end
      end
      if (req.valid && req.ready)
        outcomes.push_back(apply_request(req.opcode, req.queue_number,
                                         req.process_number));
    end
  end
endmodule

/* tb/sv/tb_top.sv */
// Top of the process link manager testbench: clock, reset, request stimulus,
// response stalls and the verdict. Depends on mqpl_pkg, mqpl_ifs, the block
// and mqpl_scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import mqpl_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   errors, pending;
  bit   calm = 0;

  mqpl_req_if req();
  mqpl_rsp_if rsp();

  multi_queue_process_link_manager_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp)
  );

  mqpl_scoreboard u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  initial begin
    rsp.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // entered and left at a falling edge; valid stays up until the next call
  task automatic issue(logic [2:0] op, logic [5:0] q, logic [4:0] p);
    while (!calm && $urandom_range(99) < 33) begin
      req.valid <= 0;
      @(negedge clk_i);
    end
    req.valid <= 1;
    req.opcode <= op;
    req.queue_number <= q;
    req.process_number <= p;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  initial begin
    int k, r;
    logic [2:0] op;
    req.valid = 0;
    req.opcode = 0;
    req.queue_number = 0;
    req.process_number = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: empty cases, fills, full entry, tail/middle removal, frees
    issue(OP_PEEK, 63, 0);
    issue(OP_REM_HEAD, 0, 0);
    issue(OP_REM_NAMED, 5, 3);
    issue(3'd6, 1, 1);
    issue(3'd7, 62, 31);
    issue(OP_ALLOC, 0, 0);
    issue(OP_INSERT, 0, 31);
    issue(OP_INSERT, 1, 31);
    issue(OP_INSERT, 2, 31);
    issue(OP_INSERT, 63, 31);
    issue(OP_INSERT, 5, 31);
    issue(OP_FREE, 0, 31);
    issue(OP_INSERT, 0, 1);
    issue(OP_INSERT, 0, 2);
    issue(OP_PEEK, 0, 0);
    issue(OP_REM_NAMED, 0, 2);
    issue(OP_REM_NAMED, 0, 1);
    issue(OP_REM_NAMED, 0, 9);
    issue(OP_REM_HEAD, 0, 0);
    issue(OP_REM_HEAD, 0, 0);
    issue(OP_REM_NAMED, 63, 31);
    issue(OP_FREE, 0, 31);
    issue(OP_FREE, 0, 31);
    for (k = 0; k < 1400; k++) begin
      calm = (k >= 500 && k < 700);
      r = $urandom_range(99);
      op = r < 8 ? OP_ALLOC : r < 14 ? OP_FREE : r < 50 ? OP_INSERT :
           r < 68 ? OP_REM_HEAD : r < 88 ? OP_REM_NAMED : r < 97 ? OP_PEEK :
           3'($urandom_range(7));
      // few queues and processes most of the time, so queues grow long
      issue(op, $urandom_range(3) != 0 ? 6'($urandom_range(5)) : 6'($urandom),
            $urandom_range(3) != 0 ? 5'($urandom_range(7)) : 5'($urandom));
    end
    req.valid <= 0;
    calm = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
